// ===== hdl/hsfr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsfr_pkg
// Shared constants and types of the header and sum frame receiver.
// ---------------------------------------------------------------------------
package hsfr_pkg;

    localparam int PAYLOAD_BYTES = 26;
    localparam int POS_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int BYTE_W = 8;
    localparam int INDEX_W = 5;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET = 8'hff;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'haa;

    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              commit;
    } store_ctrl_t;

endpackage

// ===== hdl/hsfr_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsfr_parser
// Frame parser: header match, payload capture and running sum check.
// ---------------------------------------------------------------------------
module hsfr_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         enable,
    input  logic [hsfr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [hsfr_pkg::BYTE_W-1:0]  header_first,
    input  logic [hsfr_pkg::BYTE_W-1:0]  header_second,
    output hsfr_pkg::store_ctrl_t        store_ctrl,
    output logic                         accepted,
    output logic                         rejected
);
    import hsfr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAYLOAD_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END = POS_W'(PAYLOAD_BYTES);

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        store_ctrl.wr_en = 1'b0;
        store_ctrl.wr_addr = pos_reg;
        store_ctrl.wr_data = rx_byte;
        store_ctrl.commit = 1'b0;
        accepted = 1'b0;
        rejected = 1'b0;
        if (enable)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == header_first)
                    begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND:
                begin
                    if (rx_byte == header_second)
                    begin
                        phase_next = PH_PAYLOAD;
                        pos_next = '0;
                        sum_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    store_ctrl.wr_en = 1'b1;
                    sum_next = sum_reg + rx_byte;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == POS_LAST)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (rx_byte == sum_reg)
                    begin
                        store_ctrl.commit = 1'b1;
                        accepted = 1'b1;
                    end
                    else
                    begin
                        rejected = 1'b1;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

`ifndef SYNTHESIS
    a_write_only_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctrl.wr_en |-> (phase_reg == PH_PAYLOAD))
        else $error("store write outside the payload phase");

    a_check_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CHECK) && !$past(phase_reg == PH_CHECK)
            |-> (pos_reg == POS_END) && ($past(pos_reg) == POS_LAST))
        else $error("checksum phase entered before the last payload byte");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(accepted && rejected))
        else $error("frame both accepted and rejected");
`endif

endmodule

// ===== hdl/hsfr_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsfr_store
// Two payload banks: one receives the frame, the other holds the committed
// copy. A commit swaps their roles.
// ---------------------------------------------------------------------------
module hsfr_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  hsfr_pkg::store_ctrl_t        store_ctrl,
    input  logic [hsfr_pkg::POS_W-1:0]   rd_addr,
    output logic [hsfr_pkg::BYTE_W-1:0]  rd_data
);
    import hsfr_pkg::*;

    logic [BYTE_W-1:0] bank0_reg [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] bank1_reg [PAYLOAD_BYTES];
    logic              sel_reg;
    logic              valid_reg;

    // Before the first commit the committed copy reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (store_ctrl.commit)
        begin
            sel_reg <= !sel_reg;
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_ctrl.wr_en && sel_reg)
        begin
            bank0_reg[store_ctrl.wr_addr] <= store_ctrl.wr_data;
        end
        if (store_ctrl.wr_en && !sel_reg)
        begin
            bank1_reg[store_ctrl.wr_addr] <= store_ctrl.wr_data;
        end
    end

    always_comb
    begin
        if (!valid_reg)
        begin
            rd_data = '0;
        end
        else if (sel_reg)
        begin
            rd_data = bank1_reg[rd_addr];
        end
        else
        begin
            rd_data = bank0_reg[rd_addr];
        end
    end

endmodule

// ===== hdl/header_sum_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// header_sum_frame_receiver_core
// Receives frames of two header bytes, a fixed payload and an 8-bit sum
// byte, keeps the last good payload and answers byte reads from it.
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, command, rx_byte,     beat in
//            read_index
//   out      out_valid, out_stall, read_byte,          beat out
//            frame_accepted, frame_rejected
//   cfg      cfg_write, cfg_index, cfg_data            write only
//
// Every beat passes through the input register, then through the parser and
// the bank read into the output register.
// One beat is accepted per cycle when the output side does not stall.
// The input register and the output register together hold two beats, so a
// beat is still accepted while one finished result waits.
// Reset clears the parser, the handshake state and the committed copy, which
// reads as zero until the first good frame.
// ---------------------------------------------------------------------------
module header_sum_frame_receiver_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [hsfr_pkg::BYTE_W-1:0]       rx_byte,
    input  logic [hsfr_pkg::INDEX_W-1:0]      read_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hsfr_pkg::BYTE_W-1:0]       read_byte,
    output logic                              frame_accepted,
    output logic                              frame_rejected,
    input  logic                              cfg_write,
    input  logic [hsfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsfr_pkg::BYTE_W-1:0]       cfg_data
);
    import hsfr_pkg::*;

    logic [BYTE_W-1:0]  header_first_reg;
    logic [BYTE_W-1:0]  header_second_reg;

    logic               s1_valid_reg;
    logic               s1_command_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic [INDEX_W-1:0] s1_index_reg;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  read_byte_reg;
    logic               accepted_reg;
    logic               rejected_reg;

    logic               advance;
    logic               parse_en;
    logic               in_range;
    logic [BYTE_W-1:0]  read_byte_next;
    logic               accepted;
    logic               rejected;
    logic [BYTE_W-1:0]  rd_data;
    store_ctrl_t        store_ctrl;

    assign advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign parse_en = advance && (s1_command_reg == CMD_RX_BYTE);
    assign in_range = (32'(s1_index_reg) < 32'(PAYLOAD_BYTES));
    assign read_byte_next = ((s1_command_reg == CMD_READ) && in_range) ? rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default:           header_first_reg <= header_first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_command_reg <= command;
            s1_byte_reg <= rx_byte;
            s1_index_reg <= read_index;
        end
        if (advance)
        begin
            read_byte_reg <= read_byte_next;
            accepted_reg <= accepted;
            rejected_reg <= rejected;
        end
    end

    hsfr_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (parse_en),
        .rx_byte       (s1_byte_reg),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .store_ctrl    (store_ctrl),
        .accepted      (accepted),
        .rejected      (rejected)
    );

    hsfr_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .store_ctrl (store_ctrl),
        .rd_addr    (POS_W'(s1_index_reg)),
        .rd_data    (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;
    assign frame_accepted = accepted_reg;
    assign frame_rejected = rejected_reg;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a waiting result");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach the output register");

    a_flags_mean_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (accepted_reg || rejected_reg) |-> (read_byte_reg == '0))
        else $error("frame flag raised on a read result");

    a_reads_skip_parser: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (s1_command_reg == CMD_READ) |-> !store_ctrl.wr_en && !store_ctrl.commit)
        else $error("read beat changed the payload store");
`endif

endmodule
